FILE: sv/dtq_pkg.sv
// Package for the delta timeout queue: word types, cell control and result codes.
package dtq_pkg;

  localparam int NUM_SLOTS_DEF = 8;

  localparam logic [1:0] KIND_FIRED   = 2'd0;
  localparam logic [1:0] KIND_INSERT  = 2'd1;
  localparam logic [1:0] KIND_FULL    = 2'd2;
  localparam logic [1:0] KIND_NOTHING = 2'd3;

  localparam logic CMD_CREATE  = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  typedef struct packed {
    logic        command;
    logic [30:0] delay;
    logic [30:0] reload;
    logic [7:0]  handler_id;
    logic [31:0] tag;
    logic [30:0] elapsed;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  fired_handler;
    logic [31:0] fired_tag;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [30:0] delta;
    logic [30:0] rpt;
    logic [7:0]  handler;
    logic [31:0] tag;
  } entry_t;

  typedef enum logic [1:0] {
    SEL_HOLD  = 2'd0,
    SEL_LEFT  = 2'd1,
    SEL_RIGHT = 2'd2,
    SEL_FAR   = 2'd3
  } sel_t;

  typedef struct packed {
    sel_t        sel;
    logic        dwr;
    logic [30:0] dval;
  } cell_ctrl_t;

endpackage

FILE: sv/delta_timeout_queue.sv
// Delta timeout queue top level: sorted chain of timer cells and its sequencer.
// Create: the insert word follows a walk over the stored entries, fewer than NUM_SLOTS of them.
// Advance: fired entries come out one by one, then each repeating entry is walked back in.
// A full table answers in the cycle after accept. Results are single-cycle strobes.
// Reset clears the sequencer and empties the list; cell contents are not reset.
module delta_timeout_queue #(
  parameter int NUM_SLOTS = dtq_pkg::NUM_SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  dtq_pkg::in_t  req,
  output logic          busy,
  output logic          strobe,
  output dtq_pkg::out_t result
);

  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam int IW = $clog2(NUM_SLOTS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ADV  = 3'b010,
    ST_INS  = 3'b100
  } state_t;

  state_t state, state_next;
  logic [CW-1:0] ca, ca_next, total, total_next, pos, pos_next;
  logic [30:0] rem, rem_next, dreg, dreg_next;
  logic crt, crt_next, fired, fired_next;
  logic strobe_next;
  dtq_pkg::out_t result_next;

  dtq_pkg::entry_t    q [NUM_SLOTS];
  dtq_pkg::cell_ctrl_t ctrl [NUM_SLOTS];
  dtq_pkg::entry_t    far;
  dtq_pkg::entry_t    new_entry, at_pos, at_ca, at_ca1;
  logic [CW-1:0] ca1;
  logic [30:0] rem_fire;
  logic fire, ins_here;

  genvar g;
  generate
    for (g = 0; g < NUM_SLOTS; g++) begin : g_cell
      dtq_pkg::entry_t lft, rgt;
      if (g == 0) begin : g_l0
        assign lft = q[g];
      end else begin : g_l
        assign lft = q[g-1];
      end
      if (g == NUM_SLOTS - 1) begin : g_rn
        assign rgt = q[g];
      end else begin : g_r
        assign rgt = q[g+1];
      end
      dtq_cell u_cell (
        .clk   (clk),
        .ctrl  (ctrl[g]),
        .left  (lft),
        .right (rgt),
        .far   (far),
        .q     (q[g])
      );
    end
  endgenerate

  assign busy = (state != ST_IDLE);
  assign ca1  = ca + CW'(1);

  always_comb begin
    new_entry.delta   = req.delay;
    new_entry.rpt     = req.reload;
    new_entry.handler = req.handler_id;
    new_entry.tag     = req.tag;
    at_pos = q[pos[IW-1:0]];
    at_ca  = q[ca[IW-1:0]];
    at_ca1 = q[ca1[IW-1:0]];
    case (state)
      ST_IDLE: far = new_entry;
      ST_ADV:  far = q[0];
      default: far = at_ca;
    endcase
    fire     = (ca != '0) && (q[0].delta <= rem);
    rem_fire = rem - q[0].delta;
    ins_here = (pos < ca) && (dreg <= at_pos.delta);
  end

  always_comb begin
    state_next  = state;
    ca_next     = ca;
    total_next  = total;
    pos_next    = pos;
    rem_next    = rem;
    dreg_next   = dreg;
    crt_next    = crt;
    fired_next  = fired;
    strobe_next = 1'b0;
    result_next = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      ctrl[i] = '{sel: dtq_pkg::SEL_HOLD, dwr: 1'b0, dval: '0};
    end
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (req.command == dtq_pkg::CMD_CREATE) begin
            if (ca == CW'(NUM_SLOTS)) begin
              strobe_next      = 1'b1;
              result_next.kind = dtq_pkg::KIND_FULL;
              result_next.last = 1'b1;
            end else begin
              for (int i = 0; i < NUM_SLOTS; i++) begin
                if (CW'(i) == ca) ctrl[i].sel = dtq_pkg::SEL_FAR;
              end
              total_next = ca1;
              dreg_next  = req.delay;
              pos_next   = '0;
              crt_next   = 1'b1;
              state_next = ST_INS;
            end
          end else begin
            rem_next   = req.elapsed;
            fired_next = 1'b0;
            crt_next   = 1'b0;
            state_next = ST_ADV;
          end
        end
      end
      ST_ADV: begin
        if (fire) begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (CW'(i) + CW'(1) < total) ctrl[i].sel = dtq_pkg::SEL_RIGHT;
            else if (CW'(i) + CW'(1) == total) ctrl[i].sel = dtq_pkg::SEL_FAR;
          end
          strobe_next               = 1'b1;
          result_next.kind          = dtq_pkg::KIND_FIRED;
          result_next.fired_handler = q[0].handler;
          result_next.fired_tag     = q[0].tag;
          result_next.last          = !((ca > CW'(1)) && (q[1].delta <= rem_fire));
          rem_next   = rem_fire;
          ca_next    = ca - CW'(1);
          if (q[0].rpt == '0) total_next = total - CW'(1);
          fired_next = 1'b1;
        end else begin
          if (ca != '0) begin
            ctrl[0].dwr  = 1'b1;
            ctrl[0].dval = q[0].delta - rem;
          end
          if (!fired) begin
            strobe_next      = 1'b1;
            result_next.kind = dtq_pkg::KIND_NOTHING;
            result_next.last = 1'b1;
          end
          pos_next   = '0;
          dreg_next  = at_ca.rpt;
          state_next = (ca < total) ? ST_INS : ST_IDLE;
        end
      end
      ST_INS: begin
        if (ins_here || pos >= ca) begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (ins_here) begin
              if (CW'(i) == pos) begin
                ctrl[i].sel  = dtq_pkg::SEL_FAR;
                ctrl[i].dwr  = 1'b1;
                ctrl[i].dval = dreg;
              end else if (CW'(i) == pos + CW'(1)) begin
                ctrl[i].sel  = dtq_pkg::SEL_LEFT;
                ctrl[i].dwr  = 1'b1;
                ctrl[i].dval = at_pos.delta - dreg;
              end else if (CW'(i) > pos && CW'(i) <= ca) begin
                ctrl[i].sel = dtq_pkg::SEL_LEFT;
              end
            end else if (CW'(i) == ca) begin
              ctrl[i].dwr  = 1'b1;
              ctrl[i].dval = dreg;
            end
          end
          ca_next  = ca1;
          pos_next = '0;
          if (ca1 < total) begin
            dreg_next = at_ca1.rpt;
          end else begin
            state_next = ST_IDLE;
            if (crt) begin
              strobe_next      = 1'b1;
              result_next.kind = dtq_pkg::KIND_INSERT;
              result_next.last = 1'b1;
            end
          end
        end else begin
          dreg_next = dreg - at_pos.delta;
          pos_next  = pos + CW'(1);
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      ca     <= '0;
      total  <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      ca     <= ca_next;
      total  <= total_next;
      strobe <= strobe_next;
    end
    pos    <= pos_next;
    rem    <= rem_next;
    dreg   <= dreg_next;
    crt    <= crt_next;
    fired  <= fired_next;
    result <= result_next;
  end

endmodule

FILE: sv/dtq_cell.sv
// One list cell: holds an entry, takes a neighbor's or the far bus, with delta override.
module dtq_cell (
  input  logic               clk,
  input  dtq_pkg::cell_ctrl_t ctrl,
  input  dtq_pkg::entry_t    left,
  input  dtq_pkg::entry_t    right,
  input  dtq_pkg::entry_t    far,
  output dtq_pkg::entry_t    q
);

  dtq_pkg::entry_t q_next;

  always_comb begin
    case (ctrl.sel)
      dtq_pkg::SEL_HOLD:  q_next = q;
      dtq_pkg::SEL_LEFT:  q_next = left;
      dtq_pkg::SEL_RIGHT: q_next = right;
      dtq_pkg::SEL_FAR:   q_next = far;
      default:            q_next = q;
    endcase
    if (ctrl.dwr) begin
      q_next.delta = ctrl.dval;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

FILE: sim/dtq_checker.sv
// Checker for the delta timeout queue: predicts result words and compares them.
module dtq_checker #(
  parameter int NUM_SLOTS = dtq_pkg::NUM_SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  dtq_pkg::in_t  req,
  input  logic          strobe,
  input  dtq_pkg::out_t result,
  output int            fail_count,
  output int            pending
);

  logic [31:0] t_delta   [NUM_SLOTS];
  logic [30:0] t_repeat  [NUM_SLOTS];
  logic [7:0]  t_handler [NUM_SLOTS];
  logic [31:0] t_tag     [NUM_SLOTS];
  int          order     [NUM_SLOTS];
  int          listed;
  logic [NUM_SLOTS-1:0] free_slots;
  dtq_pkg::out_t expected_words[$];

  assign pending = expected_words.size();

  function automatic dtq_pkg::out_t make_word(logic [1:0] k, logic [7:0] h, logic [31:0] t);
    dtq_pkg::out_t w;
    w.kind = k;
    w.fired_handler = h;
    w.fired_tag = t;
    w.last = 1'b0;
    return w;
  endfunction

  function automatic void sorted_insert(int s, logic [31:0] d);
    int pos;
    pos = 0;
    while (pos < listed) begin
      if (d <= t_delta[order[pos]]) begin
        t_delta[order[pos]] -= d;
        break;
      end
      d -= t_delta[order[pos]];
      pos++;
    end
    for (int i = listed; i > pos; i--) order[i] = order[i-1];
    order[pos] = s;
    t_delta[s] = d;
    listed++;
  endfunction

  function automatic void predict(dtq_pkg::in_t w);
    dtq_pkg::out_t r;
    int s;
    int fired[$];
    logic [31:0] rem;
    int n;
    if (w.command == dtq_pkg::CMD_CREATE) begin
      if (listed >= NUM_SLOTS || free_slots == '0) begin
        r = make_word(dtq_pkg::KIND_FULL, 8'd0, 32'd0);
      end else begin
        s = 0;
        while (!free_slots[s]) s++;
        free_slots[s] = 1'b0;
        t_repeat[s] = w.reload;
        t_handler[s] = w.handler_id;
        t_tag[s] = w.tag;
        sorted_insert(s, {1'b0, w.delay});
        r = make_word(dtq_pkg::KIND_INSERT, 8'd0, 32'd0);
      end
      r.last = 1'b1;
      expected_words.push_back(r);
    end else begin
      rem = {1'b0, w.elapsed};
      n = 0;
      while (listed > 0 && t_delta[order[0]] <= rem) begin
        s = order[0];
        rem -= t_delta[s];
        for (int i = 1; i < listed; i++) order[i-1] = order[i];
        listed--;
        expected_words.push_back(make_word(dtq_pkg::KIND_FIRED, t_handler[s], t_tag[s]));
        n++;
        if (t_repeat[s] != 0) fired.push_back(s);
        else free_slots[s] = 1'b1;
      end
      if (listed > 0) t_delta[order[0]] -= rem;
      foreach (fired[i]) sorted_insert(fired[i], {1'b0, t_repeat[fired[i]]});
      if (n == 0) expected_words.push_back(make_word(dtq_pkg::KIND_NOTHING, 8'd0, 32'd0));
      expected_words[$].last = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    dtq_pkg::out_t e;
    if (rst) begin
      listed <= 0;
      free_slots <= '1;
      fail_count <= 0;
      expected_words.delete();
    end else begin
      if (strobe) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word %h", result);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_words.pop_front();
          if (e.kind != result.kind || e.fired_handler != result.fired_handler ||
              e.fired_tag != result.fired_tag || e.last != result.last) begin
            if (e.kind != result.kind)
              $error("kind: expected %0d actual %0d", e.kind, result.kind);
            if (e.fired_handler != result.fired_handler)
              $error("fired_handler: expected %0d actual %0d",
                     e.fired_handler, result.fired_handler);
            if (e.fired_tag != result.fired_tag)
              $error("fired_tag: expected %h actual %h", e.fired_tag, result.fired_tag);
            if (e.last != result.last)
              $error("last: expected %0d actual %0d", e.last, result.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) predict(req);
    end
  end

endmodule

FILE: sim/testbench.sv
// Testbench top for the delta timeout queue: stimulus, clock, reset and verdict.
module testbench;

  logic          clk;
  logic          rst;
  logic          start;
  dtq_pkg::in_t  req;
  logic          busy;
  logic          strobe;
  dtq_pkg::out_t result;
  int            fail_count;
  int            pending;

  delta_timeout_queue i_dut (
    .clk(clk), .rst(rst), .start(start), .req(req),
    .busy(busy), .strobe(strobe), .result(result)
  );

  dtq_checker i_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .strobe(strobe), .result(result), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [30:0] pick31();
    case ($urandom_range(0, 5))
      0: return 31'd0;
      1: return 31'h7fffffff;
      2: return 31'($urandom);
      default: return 31'($urandom_range(0, 60));
    endcase
  endfunction

  // Hold the word until the block takes it, then drop start.
  task automatic send_word(dtq_pkg::in_t w);
    req <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_create(logic [30:0] d, logic [30:0] r, logic [7:0] h,
                             logic [31:0] t);
    dtq_pkg::in_t w;
    w = '0;
    w.command = dtq_pkg::CMD_CREATE;
    w.delay = d;
    w.reload = r;
    w.handler_id = h;
    w.tag = t;
    send_word(w);
  endtask

  task automatic send_advance(logic [30:0] e);
    dtq_pkg::in_t w;
    w = '0;
    w.command = dtq_pkg::CMD_ADVANCE;
    w.elapsed = e;
    w.delay = 31'($urandom);
    w.reload = 31'($urandom);
    w.handler_id = 8'($urandom);
    w.tag = $urandom;
    send_word(w);
  endtask

  initial begin
    int burst;
    int waited;
    dtq_pkg::in_t w;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_advance(31'd5);
    send_create(31'd0, 31'd0, 8'hff, 32'hffffffff);
    send_advance(31'd0);
    send_create(31'h7fffffff, 31'h7fffffff, 8'h00, 32'h0);
    send_create(31'd10, 31'd3, 8'h11, 32'h1111);
    send_create(31'd10, 31'd0, 8'h22, 32'h2222);
    send_create(31'd4, 31'd7, 8'h33, 32'h3333);
    send_create(31'd20, 31'd0, 8'h44, 32'h4444);
    send_create(31'd1, 31'd1, 8'h55, 32'h5555);
    send_create(31'd30, 31'd0, 8'h66, 32'h6666);
    send_create(31'd15, 31'd0, 8'h77, 32'h7777);
    send_create(31'd5, 31'd0, 8'h88, 32'h8888);
    send_advance(31'd3);
    send_advance(31'd40);
    send_advance(31'h7fffffff);
    send_advance(31'h7fffffff);
    send_advance(31'd1);

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    for (int n = 0; n < 270; ) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && n < 270; b++, n++) begin
        w.command = ($urandom_range(0, 99) < 55) ? dtq_pkg::CMD_CREATE : dtq_pkg::CMD_ADVANCE;
        w.delay = pick31();
        w.reload = ($urandom_range(0, 2) == 0) ? 31'd0 : pick31();
        w.handler_id = 8'($urandom);
        w.tag = $urandom;
        w.elapsed = ($urandom_range(0, 9) == 0) ? pick31() : 31'($urandom_range(0, 40));
        send_word(w);
      end
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 15)) @(posedge clk);
    end

    waited = 0;
    while (pending != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
